// File: src/lu8d_pkg.sv
package lu8d_pkg;

  // Lead byte classes: number of extra bytes a lead opens, or one of the
  // two codes that open nothing.
  typedef enum logic [2:0] {
    LC_ASCII   = 3'd0,
    LC_TWO     = 3'd1,
    LC_THREE   = 3'd2,
    LC_FOUR    = 3'd3,
    LC_INVALID = 3'd4
  } lead_class_t;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  localparam logic [CpWidth-1:0] Qmark = CpWidth'(63);

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               run_last;
  } result_t;

  function automatic lead_class_t lead_class(input logic [7:0] b);
    lead_class_t c;
    c = LC_INVALID;
    if (b[7] == 1'b0) begin
      c = LC_ASCII;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c = LC_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c = LC_THREE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      c = LC_FOUR;
    end
    return c;
  endfunction

  function automatic logic [CpWidth-1:0] ascii_cp(input logic [7:0] b);
    return {{(CpWidth - 8){1'b0}}, b};
  endfunction

endpackage

// File: src/lenient_utf8_decoder_top.sv
// Lenient UTF-8 decoder. Takes one text byte per transfer on the input
// channel (data_byte, end_of_text) and gives code points on the output
// channel (code_point, run_last). ASCII passes through; leads 110xxxxx,
// 1110xxxx and 11110xxx gather 1, 2 or 3 following bytes without checking
// them, so overlong forms and surrogates come out as decoded. Any other
// byte seen as a lead gives '?' (63), and a decoded value of zero gives
// nothing. When end_of_text arrives inside an open sequence the lead is
// dropped and the bytes held after it are decoded again as fresh leads;
// after the final byte the decoder is back at its reset state. One input
// byte causes zero, one or two results; run_last marks the last of them.
// Rate: one byte is taken every cycle while in_ready is high. All
// decoding sits between the sequence state registers and a four-entry
// result queue; the output side drains one result per cycle while out_ready
// is high, and in_ready drops while the queue holds more than two results.
// Results are registered in the queue before they reach the output channel.
module lenient_utf8_decoder_top
  import lu8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CpWidth-1:0] code_point,
  output logic               run_last
);

  // Sequence state
  logic [7:0] lead_byte, lead_byte_next;
  logic [7:0] held_bytes [2];
  logic [7:0] held_bytes_next [2];
  logic [1:0] held_count, held_count_next;
  logic [1:0] bytes_needed, bytes_needed_next;

  // Result queue
  result_t                queue [QueueDepth];
  logic [QPtrWidth-1:0]   wr_ptr;
  logic [QPtrWidth-1:0]   rd_ptr;
  logic [QCntWidth-1:0]   q_count;

  logic push, pop;

  // Candidates in output order: main result, then two tail results.
  logic [2:0]         cand_v;
  logic [CpWidth-1:0] cand_cp [3];

  result_t    slot0, slot1;
  logic [1:0] n_out;

  lead_class_t cls_in, cls_t0, cls_t1;
  logic        tail_on;
  logic        t1_used;

  // Next-state and result logic for the byte on the input port
  always_comb begin
    lead_byte_next     = lead_byte;
    held_bytes_next[0] = held_bytes[0];
    held_bytes_next[1] = held_bytes[1];
    held_count_next    = held_count;
    bytes_needed_next  = bytes_needed;
    cand_v             = '0;
    cand_cp[0]         = '0;
    cand_cp[1]         = '0;
    cand_cp[2]         = '0;
    cls_in             = lead_class(data_byte);

    case (bytes_needed)
      2'd0: begin
        if (cls_in == LC_ASCII) begin
          cand_v[0]  = 1'b1;
          cand_cp[0] = ascii_cp(data_byte);
        end else if (cls_in == LC_INVALID) begin
          cand_v[0]  = 1'b1;
          cand_cp[0] = Qmark;
        end else begin
          // Open a sequence
          lead_byte_next    = data_byte;
          held_count_next   = 2'd0;
          bytes_needed_next = cls_in[1:0];
        end
      end
      2'd1: begin
        // Close the sequence: lead payload on top, six bits per byte below
        cand_v[0] = 1'b1;
        case (held_count)
          2'd0:    cand_cp[0] = {10'b0, lead_byte[4:0], data_byte[5:0]};
          2'd1:    cand_cp[0] = {5'b0, lead_byte[3:0], held_bytes[0][5:0],
                                 data_byte[5:0]};
          default: cand_cp[0] = {lead_byte[2:0], held_bytes[0][5:0],
                                 held_bytes[1][5:0], data_byte[5:0]};
        endcase
        lead_byte_next     = '0;
        held_bytes_next[0] = '0;
        held_bytes_next[1] = '0;
        held_count_next    = '0;
        bytes_needed_next  = '0;
      end
      default: begin
        // Hold another byte
        held_bytes_next[held_count[0]] = data_byte;
        held_count_next                = held_count + 2'd1;
        bytes_needed_next              = bytes_needed - 2'd1;
      end
    endcase

    // End of text inside a sequence: drop the lead, decode the held bytes
    tail_on = end_of_text && (bytes_needed_next != 2'd0);
    cls_t0  = lead_class(held_bytes_next[0]);
    cls_t1  = lead_class(held_bytes_next[1]);
    t1_used = 1'b0;
    if (tail_on && held_count_next != 2'd0) begin
      if (cls_t0 == LC_ASCII) begin
        cand_v[1]  = 1'b1;
        cand_cp[1] = ascii_cp(held_bytes_next[0]);
      end else if (cls_t0 == LC_INVALID) begin
        cand_v[1]  = 1'b1;
        cand_cp[1] = Qmark;
      end else if (cls_t0 == LC_TWO && held_count_next == 2'd2) begin
        cand_v[1]  = 1'b1;
        cand_cp[1] = {10'b0, held_bytes_next[0][4:0], held_bytes_next[1][5:0]};
        t1_used    = 1'b1;
      end
    end
    if (tail_on && held_count_next == 2'd2 && !t1_used) begin
      if (cls_t1 == LC_ASCII) begin
        cand_v[2]  = 1'b1;
        cand_cp[2] = ascii_cp(held_bytes_next[1]);
      end else if (cls_t1 == LC_INVALID) begin
        cand_v[2]  = 1'b1;
        cand_cp[2] = Qmark;
      end
    end

    // Drop zero code points
    if (cand_cp[0] == '0) cand_v[0] = 1'b0;
    if (cand_cp[1] == '0) cand_v[1] = 1'b0;
    if (cand_cp[2] == '0) cand_v[2] = 1'b0;

    if (end_of_text) begin
      lead_byte_next     = '0;
      held_bytes_next[0] = '0;
      held_bytes_next[1] = '0;
      held_count_next    = '0;
      bytes_needed_next  = '0;
    end
  end

  // Pack valid candidates into at most two result slots
  always_comb begin
    slot0 = '0;
    slot1 = '0;
    n_out = 2'd0;
    if (cand_v[0]) begin
      slot0.code_point = cand_cp[0];
      n_out            = 2'd1;
    end else if (cand_v[1]) begin
      slot0.code_point = cand_cp[1];
      n_out            = 2'd1;
      if (cand_v[2]) begin
        slot1.code_point = cand_cp[2];
        n_out            = 2'd2;
      end
    end else if (cand_v[2]) begin
      slot0.code_point = cand_cp[2];
      n_out            = 2'd1;
    end
    slot0.run_last = (n_out == 2'd1);
    slot1.run_last = 1'b1;
  end

  // Accept only while the queue has room for two results
  assign in_ready   = (q_count <= QCntWidth'(QueueDepth - 2));
  assign push       = in_valid && in_ready;
  assign out_valid  = (q_count != '0);
  assign pop        = out_valid && out_ready;
  assign code_point = queue[rd_ptr].code_point;
  assign run_last   = queue[rd_ptr].run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= '0;
      held_bytes[0] <= '0;
      held_bytes[1] <= '0;
      held_count    <= '0;
      bytes_needed  <= '0;
    end else if (push) begin
      lead_byte     <= lead_byte_next;
      held_bytes[0] <= held_bytes_next[0];
      held_bytes[1] <= held_bytes_next[1];
      held_count    <= held_count_next;
      bytes_needed  <= bytes_needed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && n_out != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (push && n_out == 2'd2) begin
      queue[wr_ptr + QPtrWidth'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrWidth'(n_out);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrWidth'(1);
      end
      q_count <= q_count + (push ? QCntWidth'(n_out) : '0) - QCntWidth'(pop);
    end
  end

  // Queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    q_count <= QCntWidth'(QueueDepth))
    else $error("result queue overflow");

  // An open sequence always accounts for exactly the bytes its lead calls for
  assert property (@(posedge clk) disable iff (rst)
    bytes_needed != 2'd0 |->
      (3'(held_count) + 3'(bytes_needed) == 3'(lead_class(lead_byte))))
    else $error("sequence state out of step with lead byte");

  // Final byte of a text returns the decoder to its idle state
  assert property (@(posedge clk) disable iff (rst)
    push && end_of_text |=> bytes_needed == 2'd0 && held_count == 2'd0)
    else $error("state not cleared after end of text");

  // Queue occupancy moves only with transfers
  assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> $stable(q_count))
    else $error("queue count changed without a transfer");

endmodule
